// ===== src/btpc_pkg.sv =====
// ----------------------------------------------------------------------------
// btpc_pkg: shared types and constants for the barometric compensation block
// Register indexes, status codes and the serial multiply/divide request/response types.
// ----------------------------------------------------------------------------
package btpc_pkg;

	localparam int unsigned RawW = 20;
	localparam int unsigned WordW = 64;
	localparam int unsigned CntW = 7;

	localparam logic [1:0] REG_TEMP_CAL = 2'd0;
	localparam logic [1:0] REG_PRESS_A = 2'd1;
	localparam logic [1:0] REG_PRESS_B = 2'd2;
	localparam logic [1:0] REG_PRESS_C = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_TEMP = 2'd1;
	localparam logic [1:0] ST_ZERO_DIV = 2'd2;

	localparam logic [63:0] TEMP_OFFSET = 64'd128000;
	localparam logic [63:0] PRESS_FULLSCALE = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE = 64'd3125;

	// request to the shared serial arithmetic unit
	typedef struct packed {
		logic start;
		logic is_div;
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic [WordW-1:0] res;
	} alu_rsp_t;

endpackage

// ===== src/btpc_alu.sv =====
// ----------------------------------------------------------------------------
// btpc_alu: bit-serial multiplier and signed divider
// Shift-add multiply (low 64 bits) and restoring signed divide, one bit a cycle.
// ----------------------------------------------------------------------------
module btpc_alu (
	input logic clk,
	input logic arst_n,
	input btpc_pkg::alu_req_t req,
	output btpc_pkg::alu_rsp_t rsp
);
	import btpc_pkg::*;

	logic busy_q, div_q, neg_q, done_q;
	logic [CntW-1:0] cnt_q;
	logic [WordW-1:0] acc_q, mcand_q, mplier_q, rem_q;
	logic [WordW-1:0] abs_a, abs_b, rem_sh, sub;
	logic sub_ok;

	assign abs_a = req.a[WordW-1] ? (~req.a + 64'd1) : req.a;
	assign abs_b = req.b[WordW-1] ? (~req.b + 64'd1) : req.b;
	// restoring step: rem_q holds partial remainder, mplier_q dividend bits
	assign rem_sh = {rem_q[WordW-2:0], mplier_q[WordW-1]};
	assign sub_ok = ({rem_q[WordW-1], rem_sh} >= {1'b0, mcand_q});
	assign sub = rem_sh - mcand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(WordW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			neg_q <= req.a[WordW-1] ^ req.b[WordW-1];
			acc_q <= '0;
			rem_q <= '0;
			mcand_q <= req.is_div ? abs_b : req.a;
			mplier_q <= req.is_div ? abs_a : req.b;
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= sub_ok ? sub : rem_sh;
				mplier_q <= {mplier_q[WordW-2:0], 1'b0};
				acc_q <= {acc_q[WordW-2:0], sub_ok};
			end else begin
				if (mplier_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q <= {mcand_q[WordW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[WordW-1:1]};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = (div_q && neg_q) ? (~acc_q + 64'd1) : acc_q;

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

	property p_no_start_busy;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !done_q;
	endproperty
	a_no_start_busy: assert property (p_no_start_busy) else $error("done while busy");

	property p_cnt_idle;
		@(posedge clk) disable iff (!arst_n) $fell(busy_q) && !req.start |=> done_q == 1'b0;
	endproperty
	a_cnt_idle: assert property (p_cnt_idle) else $error("done held");
endmodule

// ===== src/btpc_seq.sv =====
// ----------------------------------------------------------------------------
// btpc_seq: compensation sequencer
// Steps through the compensation formula, issuing multiplies and the divide.
// ----------------------------------------------------------------------------
module btpc_seq (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic cmd,
	input logic [btpc_pkg::RawW-1:0] raw,
	input logic [47:0] tcal,
	input logic [63:0] pca,
	input logic [63:0] pcb,
	input logic [15:0] pcc,
	output btpc_pkg::alu_req_t req,
	input btpc_pkg::alu_rsp_t rsp,
	output logic done,
	output logic [31:0] temp_out,
	output logic [31:0] press_out,
	output logic [1:0] status_out
);
	import btpc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ISSUE = 5'b00010,
		S_WAIT = 5'b00100,
		S_CALC = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic [4:0] step_q;
	logic [RawW-1:0] raw_q;
	logic [31:0] ft_q;
	logic ftv_q;
	logic [63:0] r0_q, r1_q, r2_q, r3_q, m_q;
	logic [31:0] temp_q, press_q;
	logic [1:0] stat_q;
	logic [63:0] op_a, op_b;
	logic op_div;

	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, tf64;
	logic [31:0] t1, t2, t3;
	assign t1 = {16'd0, tcal[15:0]};
	assign t2 = {{16{tcal[31]}}, tcal[31:16]};
	assign t3 = {{16{tcal[47]}}, tcal[47:32]};
	assign p1 = {48'd0, pca[15:0]};
	assign p2 = {{48{pca[31]}}, pca[31:16]};
	assign p3 = {{48{pca[47]}}, pca[47:32]};
	assign p4 = {{48{pca[63]}}, pca[63:48]};
	assign p5 = {{48{pcb[15]}}, pcb[15:0]};
	assign p6 = {{48{pcb[31]}}, pcb[31:16]};
	assign p7 = {{48{pcb[47]}}, pcb[47:32]};
	assign p8 = {{48{pcb[63]}}, pcb[63:48]};
	assign p9 = {{48{pcc[15]}}, pcc};
	assign tf64 = {{32{ft_q[31]}}, ft_q};

	logic [31:0] ta, td, tv1, tf32;
	assign ta = {15'd0, raw_q[19:3]} - {t1[30:0], 1'b0};
	assign td = {16'd0, raw_q[19:4]} - t1;
	assign tv1 = $signed(r0_q[31:0]) >>> 11;
	assign tf32 = tv1 + 32'($signed(m_q[31:0]) >>> 14);

	// operand selection for each multiply/divide step
	always_comb begin
		op_a = '0;
		op_b = '0;
		op_div = 1'b0;
		case (step_q)
			5'd0: begin op_a = {32'd0, ta}; op_b = {32'd0, t2}; end
			5'd1: begin op_a = {32'd0, td}; op_b = {32'd0, td}; end
			5'd2: begin
				op_a = {32'd0, 32'($signed(m_q[31:0]) >>> 12)};
				op_b = {32'd0, t3};
			end
			5'd3: begin op_a = r1_q; op_b = r1_q; end
			5'd4: begin op_a = m_q; op_b = p6; end
			5'd5: begin op_a = r1_q; op_b = p5; end
			5'd6: begin op_a = r2_q; op_b = p3; end
			5'd7: begin op_a = r1_q; op_b = p2; end
			5'd8: begin op_a = r3_q; op_b = p1; end
			5'd9: begin op_a = r2_q; op_b = PRESS_SCALE; end
			5'd10: begin op_a = m_q; op_b = r0_q; op_div = 1'b1; end
			5'd11: begin op_a = p9; op_b = r3_q; end
			5'd12: begin op_a = m_q; op_b = r3_q; end
			5'd13: begin op_a = p8; op_b = r2_q; end
			default: ;
		endcase
	end

	assign req.start = (state_q == S_ISSUE);
	assign req.is_div = op_div;
	assign req.a = op_a;
	assign req.b = op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			ft_q <= '0;
			ftv_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						step_q <= cmd ? 5'd3 : 5'd0;
						state_q <= (cmd && !ftv_q) ? S_DONE : S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: if (rsp.done) state_q <= S_CALC;
				S_CALC: begin
					step_q <= step_q + 5'd1;
					state_q <= S_ISSUE;
					if (step_q == 5'd2) begin
						ft_q <= tf32;
						ftv_q <= 1'b1;
						state_q <= S_DONE;
					end else if (step_q == 5'd8 && m_q[63:33] == '0) begin
						state_q <= S_DONE;
					end else if (step_q == 5'd13) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath updates after each serial result (m_q)
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			raw_q <= raw;
			temp_q <= '0;
			press_q <= '0;
			stat_q <= (cmd && !ftv_q) ? ST_NO_TEMP : ST_OK;
			r1_q <= tf64 - TEMP_OFFSET;
		end
		if (state_q == S_WAIT && rsp.done)
			m_q <= rsp.res;
		if (state_q == S_CALC) begin
			case (step_q)
				5'd0: r0_q <= m_q;
				5'd2: temp_q <= 32'($signed(tf32 * 32'd5 + 32'd128) >>> 8);
				5'd3: r2_q <= m_q;
				5'd4: r0_q <= m_q;
				5'd5: r0_q <= r0_q + {m_q[46:0], 17'd0} + {p4[28:0], 35'd0};
				5'd6: r3_q <= $signed(m_q) >>> 8;
				5'd7: r3_q <= (r3_q + {m_q[51:0], 12'd0}) + 64'h0000_8000_0000_0000;
				5'd8: begin
					r3_q <= $signed(m_q) >>> 33;
					r2_q <= ((PRESS_FULLSCALE - {44'd0, raw_q}) << 31) - r0_q;
					if (m_q[63:33] == '0) stat_q <= ST_ZERO_DIV;
				end
				5'd9: r2_q <= m_q;
				default: ;
			endcase
		end
		// r2/r3/r0 reuse: step 8 writes the divisor into r0 as well as r3, for the divide
		if (state_q == S_CALC && step_q == 5'd8)
			r0_q <= $signed(m_q) >>> 33;
		if (state_q == S_CALC && step_q == 5'd10) begin
			r2_q <= m_q;
			r3_q <= $signed(m_q) >>> 13;
		end
		if (state_q == S_CALC && step_q == 5'd11)
			r1_q <= $signed(m_q) >>> 0;
		if (state_q == S_CALC && step_q == 5'd12)
			r1_q <= $signed(m_q) >>> 25;
		if (state_q == S_CALC && step_q == 5'd13)
			press_q <= 32'(64'($signed(r2_q + r1_q + 64'($signed(m_q) >>> 19)) >>> 8)
				+ {p7[59:0], 4'd0});
	end

	// step 9 operand: needs r2 = p_shifted - v2; step 8 wrote r2 so step 9 uses it
	assign done = (state_q == S_DONE);
	assign temp_out = temp_q;
	assign press_out = press_q;
	assign status_out = stat_q;

	property p_nt_status;
		@(posedge clk) disable iff (!arst_n)
			(state_q == S_IDLE && start && cmd && !ftv_q) |=> stat_q == ST_NO_TEMP;
	endproperty
	a_nt_status: assert property (p_nt_status) else $error("no-temp status lost");

	property p_temp_sets_valid;
		@(posedge clk) disable iff (!arst_n)
			(state_q == S_CALC && step_q == 5'd2) |=> ftv_q;
	endproperty
	a_temp_sets_valid: assert property (p_temp_sets_valid) else $error("fine temp not valid");

	property p_issue_waits;
		@(posedge clk) disable iff (!arst_n) state_q == S_ISSUE |=> state_q == S_WAIT;
	endproperty
	a_issue_waits: assert property (p_issue_waits) else $error("issue skipped wait");
endmodule

// ===== src/baro_temp_press_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_temp_press_compensation: integer temperature/pressure compensation
// Serial multiply/divide driven by a step sequencer, with an output register.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  in        in_valid/stall   command, raw_reading
//  out       out_valid/stall  result_kind, temperature_centi, pressure_q24_8, status
//  cfg       cfg_valid/ready  cfg_index, cfg_data
//
//  Each serial operation runs on the one-bit-a-cycle shared unit.
//  Temperature: 3 multiplies; pressure: 10 multiplies and one divide, ending
//  early with ST_ZERO_DIV on a zero divisor. Pressure with no temperature yet
//  skips the arithmetic and reports ST_NO_TEMP. One item in flight at a time.
//  Reset clears fine-temperature validity and all calibration registers.
//  A stalled result sits in the output register; the next item waits for it.
module baro_temp_press_compensation (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic command,
	input logic [19:0] raw_reading,
	output logic out_valid,
	input logic out_stall,
	output logic result_kind,
	output logic [31:0] temperature_centi,
	output logic [31:0] pressure_q24_8,
	output logic [1:0] status,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data
);
	import btpc_pkg::*;

	logic [47:0] tcal_q;
	logic [63:0] pca_q, pcb_q;
	logic [15:0] pcc_q;
	logic busy_q, kind_q;
	logic start, sdone;
	logic [31:0] t_o, p_o;
	logic [1:0] s_o;
	alu_req_t req;
	alu_rsp_t rsp;

	assign cfg_ready = 1'b1;
	assign in_stall = busy_q || out_valid;
	assign start = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			pca_q <= '0;
			pcb_q <= '0;
			pcc_q <= '0;
			busy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TEMP_CAL: tcal_q <= cfg_data[47:0];
					REG_PRESS_A: pca_q <= cfg_data;
					REG_PRESS_B: pcb_q <= cfg_data;
					REG_PRESS_C: pcc_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (start) busy_q <= 1'b1;
			else if (sdone) busy_q <= 1'b0;
			if (sdone) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) kind_q <= command;
		if (sdone) begin
			result_kind <= kind_q;
			temperature_centi <= t_o;
			pressure_q24_8 <= p_o;
			status <= s_o;
		end
	end

	btpc_alu u_alu (.clk, .arst_n, .req, .rsp);

	btpc_seq u_seq (
		.clk, .arst_n, .start, .cmd(command), .raw(raw_reading),
		.tcal(tcal_q), .pca(pca_q), .pcb(pcb_q), .pcc(pcc_q),
		.req, .rsp, .done(sdone), .temp_out(t_o), .press_out(p_o), .status_out(s_o)
	);

	property p_one_in_flight;
		@(posedge clk) disable iff (!arst_n) busy_q |-> in_stall;
	endproperty
	a_one_in_flight: assert property (p_one_in_flight) else $error("accept while busy");

	property p_done_busy;
		@(posedge clk) disable iff (!arst_n) sdone |-> busy_q;
	endproperty
	a_done_busy: assert property (p_done_busy) else $error("result without item");

	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n) sdone |-> !out_valid;
	endproperty
	a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");
endmodule
